@@ rtl/tsss_pkg.sv @@
// Shared types, constants and helper functions for the split selector.
// Used by time_series_split_selector_unit; no dependencies.
package tsss_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int SEG_W        = 4;
  localparam int SUB_W        = 7;
  localparam int LEN_W        = 13;
  localparam int GAIN_W       = 64;
  localparam int QUO_W        = 72;

  localparam logic [LEN_W-1:0] OFS_MAX = '1;

  localparam logic [1:0] CFG_NUM_CHILDREN = 2'd0;
  localparam logic [1:0] CFG_TRADEOFF     = 2'd1;
  localparam logic [1:0] CFG_SUBSEGS      = 2'd2;

  localparam logic [4:0]  NCH_MIN   = 5'd2;
  localparam logic [4:0]  NCH_MAX   = 5'd16;
  localparam logic [15:0] TRADE_RST = 16'd256;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_PREP = 11'b00000000010,
    ST_DIVW = 11'b00000000100,
    ST_DIVD = 11'b00000001000,
    ST_SQ   = 11'b00000010000,
    ST_DIVS = 11'b00000100000,
    ST_GAIN = 11'b00001000000,
    ST_CMP  = 11'b00010000000,
    ST_UP   = 11'b00100000000,
    ST_DN   = 11'b01000000000,
    ST_FIN  = 11'b10000000000
  } state_t;

  // Clamp a magnitude to the signed 64-bit range and apply the sign.
  function automatic logic signed [GAIN_W-1:0] sat_gain(input logic neg,
                                                        input logic [QUO_W-1:0] r);
    logic [QUO_W-1:0]  cap;
    logic [QUO_W-1:0]  c;
    logic [GAIN_W-1:0] v;
    cap = neg ? {8'd0, 1'b1, 63'd0} : {8'd0, 1'b0, {63{1'b1}}};
    c   = (r > cap) ? cap : r;
    v   = c[GAIN_W-1:0];
    return neg ? $signed(~v + 64'd1) : $signed(v);
  endfunction

  function automatic logic [LEN_W-1:0] add_sat(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? OFS_MAX : s[LEN_W-1:0];
  endfunction

endpackage

@@ rtl/time_series_split_selector_unit.sv @@
// Split selector top level: sequencer, shared 36x18 multiply-accumulate and
// shared radix-2 divider. Depends on tsss_pkg.
//
// One item is taken at a time and is worked in steps, N being the child
// count: a 33-step and a 32-step division by N on the shared divider, N+3
// squares on the shared multiplier, a 52-step division for the deviation
// mean, the two gains, and on a new best either a multiply by the tradeoff
// (segment) or a division by the tradeoff (subsegment). The result of the
// last item sits in an output register; later items are still taken while
// it waits, and a later last item holds in its final step until the waiting
// result is taken. Configuration is written only while idle.
module time_series_split_selector_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 is_subsegment,
  input  logic signed [31:0]                   lowest_mean,
  input  logic signed [31:0]                   max_mean,
  input  logic [30:0]                          min_dev,
  input  logic [30:0]                          max_dev,
  input  logic [tsss_pkg::LEN_W-1:0]           span_length,
  input  logic                                 is_last,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 vertical,
  output logic                                 mode,
  output logic [tsss_pkg::SEG_W-1:0]           segment_index,
  output logic [tsss_pkg::SUB_W-1:0]           subsegment_index,
  output logic [tsss_pkg::LEN_W-1:0]           split_offset,
  output logic [tsss_pkg::LEN_W-1:0]           split_length,
  output logic signed [31:0]                   breakpoint_base,
  output logic signed [31:0]                   breakpoint_step,
  output logic signed [tsss_pkg::GAIN_W-1:0]   best_gain,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [15:0]                          cfg_data
);

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_18 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;
  localparam logic [1:0] SH_36 = 2'd3;

  tsss_pkg::state_t state;

  logic [4:0]  nch;
  logic [15:0] trd;
  logic [4:0]  n_eff;
  logic [15:0] t_eff;

  logic                        l_sub, l_last;
  logic signed [31:0]          l_mn, l_mx;
  logic [30:0]                 l_dmin, l_dmax;
  logic [tsss_pkg::LEN_W-1:0]  l_len;

  logic signed [32:0] w_r;
  logic signed [31:0] dd_r;
  logic [32:0]        wabs_r;
  logic [31:0]        wcabs_r;
  logic signed [31:0] wc_r, d_r;
  logic [35:0]        x_r;
  logic signed [36:0] term_r;
  logic [4:0]         cnt;
  logic [2:0]         step;
  logic [47:0]        sq_w, sq_wc, sq_dmax, avg_r, dm_r, ds_r;
  logic [51:0]        sum_r;
  logic               ds_neg;
  logic signed [63:0] gm_r, gs_r, best_p, best_v;
  logic [63:0]        m_r;
  logic               g_neg;

  logic [79:0] acc, prod_sh, acc_sum;
  logic [35:0] mul_a;
  logic [17:0] mul_b;
  logic [1:0]  mul_sh;
  logic        mul_first;
  logic [53:0] prod;

  logic                       div_run, div_ge;
  logic [6:0]                 div_cnt;
  logic [tsss_pkg::QUO_W-1:0] div_q;
  logic [15:0]                div_r, div_d;
  logic [16:0]                div_rs, div_sub;

  logic [tsss_pkg::SEG_W-1:0] seg_cnt, seg_prev, seg_cur;
  logic [tsss_pkg::SUB_W-1:0] sub_cnt, sub_cur;
  logic [tsss_pkg::LEN_W-1:0] seg_ofs, sub_ofs, ofs_cur;

  logic                       ch_vert, ch_mode;
  logic [tsss_pkg::SEG_W-1:0] ch_seg;
  logic [tsss_pkg::SUB_W-1:0] ch_sub;
  logic [tsss_pkg::LEN_W-1:0] ch_ofs, ch_len;
  logic signed [31:0]         ch_base, ch_step;

  logic [32:0]        w_abs_c;
  logic [31:0]        dd_abs_c;
  logic [47:0]        sq_v;
  logic signed [36:0] term_nx;
  logic [36:0]        term_abs_c;
  logic [48:0]        ds49, ds_abs_c;
  logic signed [63:0] cmp_best, b1, g_win;
  logic               win_m, win_s;
  logic [63:0]        g_abs;

  assign n_eff = (nch < tsss_pkg::NCH_MIN) ? tsss_pkg::NCH_MIN :
                 (nch > tsss_pkg::NCH_MAX) ? tsss_pkg::NCH_MAX : nch;
  assign t_eff = (trd == 16'd0) ? 16'd1 : trd;

  assign item_stall = (state != tsss_pkg::ST_IDLE);
  assign cfg_ready  = (state == tsss_pkg::ST_IDLE);

  assign w_abs_c    = w_r[32] ? 33'(-w_r) : 33'(w_r);
  assign dd_abs_c   = dd_r[31] ? 32'(-dd_r) : 32'(dd_r);
  assign sq_v       = acc[63:16];
  assign term_nx    = term_r - 37'(d_r);
  assign term_abs_c = term_nx[36] ? 37'(-term_nx) : 37'(term_nx);
  assign ds49       = {1'b0, sq_dmax} - {1'b0, avg_r};
  assign ds_abs_c   = ds49[48] ? (~ds49 + 49'd1) : ds49;

  assign cmp_best = l_sub ? best_v : best_p;
  assign win_m    = gm_r > cmp_best;
  assign b1       = win_m ? gm_r : cmp_best;
  assign win_s    = gs_r > b1;
  assign g_win    = win_s ? gs_r : gm_r;
  assign g_abs    = g_win[63] ? 64'(-g_win) : 64'(g_win);

  assign seg_prev = (seg_cnt == '0) ? tsss_pkg::SEG_W'(tsss_pkg::MAX_SEGMENTS - 1)
                                    : seg_cnt - 1'b1;
  assign seg_cur  = l_sub ? seg_prev : seg_cnt;
  assign sub_cur  = l_sub ? sub_cnt : sub_cnt - 1'b1;
  assign ofs_cur  = l_sub ? sub_ofs : seg_ofs;

  assign div_rs  = {div_r, div_q[tsss_pkg::QUO_W-1]};
  assign div_ge  = div_rs >= {1'b0, div_d};
  assign div_sub = div_rs - {1'b0, div_d};

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_sh    = SH_0;
    mul_first = 1'b0;
    case (state)
      tsss_pkg::ST_SQ: begin
        mul_a = x_r;
        if (step == 3'd0) begin
          mul_b     = x_r[17:0];
          mul_first = 1'b1;
        end else if (step == 3'd1) begin
          mul_b  = x_r[35:18];
          mul_sh = SH_18;
        end
      end
      tsss_pkg::ST_GAIN: begin
        mul_b = {5'd0, l_len};
        if (step == 3'd1) begin
          mul_a     = dm_r[35:0];
          mul_first = 1'b1;
        end else if (step == 3'd2) begin
          mul_a  = {24'd0, dm_r[47:36]};
          mul_sh = SH_36;
        end else if (step == 3'd4) begin
          mul_a     = ds_r[35:0];
          mul_first = 1'b1;
        end else if (step == 3'd5) begin
          mul_a  = {24'd0, ds_r[47:36]};
          mul_sh = SH_36;
        end
      end
      tsss_pkg::ST_UP: begin
        mul_b = {2'd0, t_eff};
        if (step == 3'd0) begin
          mul_a     = {4'd0, m_r[31:0]};
          mul_first = 1'b1;
        end else if (step == 3'd1) begin
          mul_a  = {4'd0, m_r[63:32]};
          mul_sh = SH_32;
        end
      end
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (mul_sh)
      SH_0:    prod_sh = {26'd0, prod};
      SH_18:   prod_sh = {8'd0, prod, 18'd0};
      SH_32:   prod_sh = {prod[47:0], 32'd0};
      SH_36:   prod_sh = {prod[43:0], 36'd0};
      default: prod_sh = '0;
    endcase
  end

  assign acc_sum = (mul_first ? 80'd0 : acc) + prod_sh;

  always_ff @(posedge clk) begin
    acc <= acc_sum;
    if (rst) begin
      state        <= tsss_pkg::ST_IDLE;
      nch          <= tsss_pkg::NCH_MIN;
      trd          <= tsss_pkg::TRADE_RST;
      best_p       <= {1'b1, 63'd0};
      best_v       <= {1'b1, 63'd0};
      seg_cnt      <= '0;
      sub_cnt      <= '0;
      seg_ofs      <= '0;
      sub_ofs      <= '0;
      ch_vert      <= 1'b0;
      ch_mode      <= 1'b0;
      ch_seg       <= '0;
      ch_sub       <= '0;
      ch_ofs       <= '0;
      ch_len       <= '0;
      ch_base      <= '0;
      ch_step      <= '0;
      result_valid <= 1'b0;
      div_run      <= 1'b0;
      div_cnt      <= '0;
      step         <= '0;
      cnt          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tsss_pkg::CFG_NUM_CHILDREN: nch <= cfg_data[4:0];
          tsss_pkg::CFG_TRADEOFF:     trd <= cfg_data;
          tsss_pkg::CFG_SUBSEGS: begin
            // framing only: positions follow item order
          end
          default: begin
          end
        endcase
      end

      if (result_valid && !result_stall && !(state == tsss_pkg::ST_FIN && l_last)) begin
        result_valid <= 1'b0;
      end

      case (state)
        tsss_pkg::ST_IDLE: begin
          if (item_valid) begin
            l_sub  <= is_subsegment;
            l_last <= is_last;
            l_mn   <= lowest_mean;
            l_mx   <= max_mean;
            l_dmin <= min_dev;
            l_dmax <= max_dev;
            l_len  <= span_length;
            state  <= tsss_pkg::ST_PREP;
          end
        end
        tsss_pkg::ST_PREP: begin
          w_r   <= 33'(l_mx) - 33'(l_mn);
          dd_r  <= $signed({1'b0, l_dmax}) - $signed({1'b0, l_dmin});
          state <= tsss_pkg::ST_DIVW;
        end
        tsss_pkg::ST_DIVW: begin
          if (!div_run) begin
            div_run <= 1'b1;
            div_q   <= {w_abs_c, 39'd0};
            div_r   <= '0;
            div_d   <= {11'd0, n_eff};
            div_cnt <= 7'd33;
            wabs_r  <= w_abs_c;
          end else if (div_cnt != '0) begin
            div_r   <= div_ge ? div_sub[15:0] : div_rs[15:0];
            div_q   <= {div_q[tsss_pkg::QUO_W-2:0], div_ge};
            div_cnt <= div_cnt - 7'd1;
          end else begin
            div_run <= 1'b0;
            wcabs_r <= div_q[31:0];
            wc_r    <= w_r[32] ? (~div_q[31:0] + 32'd1) : div_q[31:0];
            state   <= tsss_pkg::ST_DIVD;
          end
        end
        tsss_pkg::ST_DIVD: begin
          if (!div_run) begin
            div_run <= 1'b1;
            div_q   <= {dd_abs_c, 40'd0};
            div_r   <= '0;
            div_d   <= {11'd0, n_eff};
            div_cnt <= 7'd32;
          end else if (div_cnt != '0) begin
            div_r   <= div_ge ? div_sub[15:0] : div_rs[15:0];
            div_q   <= {div_q[tsss_pkg::QUO_W-2:0], div_ge};
            div_cnt <= div_cnt - 7'd1;
          end else begin
            div_run <= 1'b0;
            d_r     <= dd_r[31] ? (~div_q[31:0] + 32'd1) : div_q[31:0];
            x_r     <= {3'd0, wabs_r};
            sum_r   <= '0;
            cnt     <= '0;
            step    <= '0;
            state   <= tsss_pkg::ST_SQ;
          end
        end
        tsss_pkg::ST_SQ: begin
          if (step != 3'd2) begin
            step <= step + 3'd1;
          end else begin
            step <= '0;
            case (cnt)
              5'd0:    sq_w    <= sq_v;
              5'd1:    sq_wc   <= sq_v;
              5'd2:    sq_dmax <= sq_v;
              default: sum_r   <= sum_r + {4'd0, sq_v};
            endcase
            if (cnt == n_eff + 5'd2) begin
              state <= tsss_pkg::ST_DIVS;
            end else begin
              cnt <= cnt + 5'd1;
              case (cnt)
                5'd0: x_r <= {4'd0, wcabs_r};
                5'd1: x_r <= {5'd0, l_dmax};
                5'd2: begin
                  x_r    <= {5'd0, l_dmax};
                  term_r <= $signed({6'd0, l_dmax});
                end
                default: begin
                  x_r    <= term_abs_c[35:0];
                  term_r <= term_nx;
                end
              endcase
            end
          end
        end
        tsss_pkg::ST_DIVS: begin
          if (!div_run) begin
            div_run <= 1'b1;
            div_q   <= {sum_r, 20'd0};
            div_r   <= '0;
            div_d   <= {11'd0, n_eff};
            div_cnt <= 7'd52;
          end else if (div_cnt != '0) begin
            div_r   <= div_ge ? div_sub[15:0] : div_rs[15:0];
            div_q   <= {div_q[tsss_pkg::QUO_W-2:0], div_ge};
            div_cnt <= div_cnt - 7'd1;
          end else begin
            div_run <= 1'b0;
            avg_r   <= div_q[47:0];
            step    <= '0;
            state   <= tsss_pkg::ST_GAIN;
          end
        end
        tsss_pkg::ST_GAIN: begin
          step <= step + 3'd1;
          case (step)
            3'd0: begin
              dm_r   <= sq_w - sq_wc;
              ds_r   <= ds_abs_c[47:0];
              ds_neg <= ds49[48];
            end
            3'd3: gm_r <= $signed(acc[63:0]);
            3'd6: begin
              gs_r  <= ds_neg ? $signed(~acc[63:0] + 64'd1) : $signed(acc[63:0]);
              state <= tsss_pkg::ST_CMP;
            end
            default: begin
            end
          endcase
        end
        tsss_pkg::ST_CMP: begin
          step <= '0;
          if (win_m || win_s) begin
            ch_vert <= l_sub;
            ch_mode <= win_s;
            ch_seg  <= seg_cur;
            ch_sub  <= sub_cur;
            ch_ofs  <= ofs_cur;
            ch_len  <= l_len;
            ch_base <= win_s ? $signed({1'b0, l_dmin}) : l_mn;
            ch_step <= win_s ? d_r : wc_r;
            m_r     <= g_abs;
            g_neg   <= g_win[63];
            if (l_sub) begin
              best_v <= g_win;
              state  <= tsss_pkg::ST_DN;
            end else begin
              best_p <= g_win;
              state  <= tsss_pkg::ST_UP;
            end
          end else begin
            state <= tsss_pkg::ST_FIN;
          end
        end
        tsss_pkg::ST_UP: begin
          step <= step + 3'd1;
          if (step == 3'd2) begin
            best_v <= tsss_pkg::sat_gain(g_neg, acc[79:8]);
            state  <= tsss_pkg::ST_FIN;
          end
        end
        tsss_pkg::ST_DN: begin
          if (!div_run) begin
            div_run <= 1'b1;
            div_q   <= {m_r, 8'd0};
            div_r   <= '0;
            div_d   <= t_eff;
            div_cnt <= 7'd72;
          end else if (div_cnt != '0) begin
            div_r   <= div_ge ? div_sub[15:0] : div_rs[15:0];
            div_q   <= {div_q[tsss_pkg::QUO_W-2:0], div_ge};
            div_cnt <= div_cnt - 7'd1;
          end else begin
            div_run <= 1'b0;
            best_p  <= tsss_pkg::sat_gain(g_neg, div_q);
            state   <= tsss_pkg::ST_FIN;
          end
        end
        tsss_pkg::ST_FIN: begin
          if (!(l_last && result_valid && result_stall)) begin
            state <= tsss_pkg::ST_IDLE;
            if (l_last) begin
              vertical         <= ch_vert;
              mode             <= ch_mode;
              segment_index    <= ch_seg;
              subsegment_index <= ch_sub;
              split_offset     <= ch_ofs;
              split_length     <= ch_len;
              breakpoint_base  <= ch_base;
              breakpoint_step  <= ch_step;
              best_gain        <= best_p;
              result_valid     <= 1'b1;
              best_p           <= {1'b1, 63'd0};
              best_v           <= {1'b1, 63'd0};
              seg_cnt          <= '0;
              sub_cnt          <= '0;
              seg_ofs          <= '0;
              sub_ofs          <= '0;
              ch_vert          <= 1'b0;
              ch_mode          <= 1'b0;
              ch_seg           <= '0;
              ch_sub           <= '0;
              ch_ofs           <= '0;
              ch_len           <= '0;
              ch_base          <= '0;
              ch_step          <= '0;
            end else if (l_sub) begin
              sub_cnt <= sub_cnt + 1'b1;
              sub_ofs <= tsss_pkg::add_sat(sub_ofs, l_len);
            end else begin
              seg_cnt <= (seg_cnt == tsss_pkg::SEG_W'(tsss_pkg::MAX_SEGMENTS - 1))
                         ? '0 : seg_cnt + 1'b1;
              seg_ofs <= tsss_pkg::add_sat(seg_ofs, l_len);
            end
          end
        end
        default: state <= tsss_pkg::ST_IDLE;
      endcase
    end
  end

  // a new result only comes out of the final step
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == tsss_pkg::ST_FIN))
    else $error("result raised outside final step");

  a_up_segment_only: assert property (@(posedge clk) disable iff (rst)
    (state == tsss_pkg::ST_UP) |-> !l_sub)
    else $error("scale up on a subsegment");

  a_dn_subsegment_only: assert property (@(posedge clk) disable iff (rst)
    (state == tsss_pkg::ST_DN) |-> l_sub)
    else $error("scale down on a segment");

  a_transfer_starts_work: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == tsss_pkg::ST_PREP))
    else $error("accepted item did not start");

endmodule
